>>> hdl/wgm_pkg.sv
// Shared constants and types for the wildcard glob matcher.
package wgm_pkg;

	localparam int unsigned PATTERN_MAX_DEF = 32;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned LEN_W           = 6;
	localparam int unsigned CFG_INDEX_W     = 3;
	localparam int unsigned CFG_DATA_W      = 64;
	localparam int unsigned WORD_COUNT      = 4;
	localparam int unsigned PATTERN_BYTES   = WORD_COUNT * (CFG_DATA_W / BYTE_W);

	localparam logic [BYTE_W-1:0] STAR_BYTE     = 8'h2A;
	localparam logic [BYTE_W-1:0] QUESTION_BYTE = 8'h3F;

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES_A = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES_B = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES_C = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES_D = 3'd4;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic step;
		logic rearm;
	} cmd_t;

	typedef struct packed {
		logic carry;
		logic adv;
	} link_t;

endpackage

>>> hdl/wgm_channels.sv
// Handshake channel interfaces: sample input, match result, register write.
interface wgm_sample_if;
	logic                valid;
	logic                ready;
	wgm_pkg::byte_t      sample_byte;
	logic                end_of_sample;

	modport source (output valid, output sample_byte, output end_of_sample, input ready);
	modport sink (input valid, input sample_byte, input end_of_sample, output ready);
endinterface

interface wgm_result_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink (input valid, input matched, output ready);
endinterface

interface wgm_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [wgm_pkg::CFG_INDEX_W-1:0]    index;
	logic [wgm_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/wildcard_glob_matcher_unit.sv
// Top level of the wildcard glob matcher: registers, cell row and result buffer.
//
//  channel  | dir | payload                        | transfer when
//  ---------+-----+--------------------------------+----------------------
//  cfg      | in  | index[2:0], data[63:0]         | valid & ready (ready=1)
//  sample   | in  | sample_byte[7:0], end_of_sample| valid & ready
//  result   | out | matched                        | valid & ready
//
// One sample item per cycle while sample ready is high; the row of position cells updates all alive bits in
// the cycle of the transfer, star closure ripples through the row like a carry.
// A result is registered from its end item and sits in a two-entry buffer;
// sample ready drops only when both entries hold results.
// Reset leaves only position 0 alive, all configuration registers zero.
module wildcard_glob_matcher_unit #(
	parameter int unsigned PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
	input logic             clk,
	input logic             arst_n,
	wgm_cfg_if.sink         cfg,
	wgm_sample_if.sink      sample,
	wgm_result_if.source    result
);

	localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
	localparam int unsigned CW = (LW > wgm_pkg::LEN_W) ? LW : wgm_pkg::LEN_W;

	logic [wgm_pkg::LEN_W-1:0]                          len_q;
	logic [wgm_pkg::WORD_COUNT-1:0][wgm_pkg::CFG_DATA_W-1:0] word_q;

	logic [CW-1:0]          len_raw;
	logic [CW-1:0]          len_sat;
	logic [LW-1:0]          len_eff;
	wgm_pkg::cmd_t          cmd;
	wgm_pkg::link_t         lnk [0:PATTERN_MAX];
	logic [PATTERN_MAX:0]   closed;
	logic                   tail_q;
	logic                   push;
	logic                   pop;
	logic                   out_v_q;
	logic                   out_m_q;
	logic                   skid_v_q;
	logic                   skid_m_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			word_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				wgm_pkg::REG_PATTERN_LENGTH:  len_q <= cfg.data[wgm_pkg::LEN_W-1:0];
				wgm_pkg::REG_PATTERN_BYTES_A: word_q[0] <= cfg.data;
				wgm_pkg::REG_PATTERN_BYTES_B: word_q[1] <= cfg.data;
				wgm_pkg::REG_PATTERN_BYTES_C: word_q[2] <= cfg.data;
				wgm_pkg::REG_PATTERN_BYTES_D: word_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign len_raw = CW'(len_q);
	assign len_sat = (len_raw > CW'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : len_raw;
	assign len_eff = LW'(len_sat);

	assign cmd.step  = sample.valid & sample.ready;
	assign cmd.rearm = sample.end_of_sample;

	assign lnk[0] = '0;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		wgm_pkg::byte_t pbyte;
		logic           en;
		logic           act;

		if (i < wgm_pkg::PATTERN_BYTES) begin : g_reg
			assign pbyte = word_q[i / 8][(i % 8) * 8 +: 8];
		end else begin : g_zero
			assign pbyte = '0;
		end

		assign en  = (LW'(i) <= len_eff);
		assign act = (LW'(i) < len_eff);

		wgm_cell #(
			.HOME (i == 0)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.en           (en),
			.act          (act),
			.pattern_byte (pbyte),
			.sample_byte  (sample.sample_byte),
			.lnk_in       (lnk[i]),
			.lnk_out      (lnk[i+1]),
			.closed       (closed[i])
		);
	end

	// position past the last pattern byte
	assign closed[PATTERN_MAX] = (tail_q | lnk[PATTERN_MAX].carry) &
		(len_eff == LW'(PATTERN_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
		end else if (cmd.step) begin
			tail_q <= cmd.rearm ? 1'b0 : lnk[PATTERN_MAX].adv;
		end
	end

	assign push = cmd.step & sample.end_of_sample;
	assign pop  = out_v_q & result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			out_v_q  <= skid_v_q | push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_m_q <= skid_v_q ? skid_m_q : closed[len_eff];
		end
		if (push) begin
			skid_m_q <= closed[len_eff];
		end
	end

	assign sample.ready  = ~skid_v_q;
	assign result.valid  = out_v_q;
	assign result.matched = out_m_q;

endmodule

>>> hdl/wgm_cell.sv
// One pattern position: alive bit, star closure carry and byte compare.
module wgm_cell #(
	parameter bit HOME = 1'b0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  wgm_pkg::cmd_t   cmd,
	input  logic            en,
	input  logic            act,
	input  wgm_pkg::byte_t  pattern_byte,
	input  wgm_pkg::byte_t  sample_byte,
	input  wgm_pkg::link_t  lnk_in,
	output wgm_pkg::link_t  lnk_out,
	output logic            closed
);

	logic alive_q;
	logic is_star;
	logic hit;
	logic live;

	assign is_star = (pattern_byte == wgm_pkg::STAR_BYTE);
	assign hit     = (pattern_byte == wgm_pkg::QUESTION_BYTE) || (pattern_byte == sample_byte);
	assign closed  = en & (alive_q | lnk_in.carry);
	assign live    = closed & act;

	assign lnk_out.carry = live & is_star;
	assign lnk_out.adv   = live & ~is_star & hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= HOME;
		end else if (cmd.step) begin
			alive_q <= cmd.rearm ? HOME : ((live & is_star) | lnk_in.adv);
		end
	end

endmodule

>>> hdl/wgm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to the top level.
module wgm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_end,
	input logic out_valid,
	input logic out_ready,
	input logic out_matched
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_matched))
		else $error("result changed while stalled");

	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_end))
		else $error("result without end transfer");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty result buffer");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_end && !out_valid |=> out_valid)
		else $error("end transfer produced no result");

endmodule

bind wildcard_glob_matcher_unit wgm_checker u_wgm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.in_end      (sample.end_of_sample),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_matched (result.matched)
);
